FILE: rtl/server_hello_parser_top_defines.svh
// ----------------------------------------------------------------------------
// server hello parser assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SERVER_HELLO_PARSER_TOP_DEFINES_SVH
`define SERVER_HELLO_PARSER_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define SHP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("server hello parser check failed");

// next-cycle implication, quiet during reset
`define SHP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("server hello parser check failed");

`endif

FILE: rtl/shp_pkg.sv
// ----------------------------------------------------------------------------
// shp_pkg
// types and constants shared by the server hello parser modules
// ----------------------------------------------------------------------------
`default_nettype none

package shp_pkg;

    localparam int RANDOM_BYTES      = 32;
    localparam int PUBLIC_KEY_BYTES  = 64;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam logic [7:0]  REC_TYPE_HS     = 8'd22;
    localparam logic [15:0] LEGACY_VER      = 16'h0303;
    localparam logic [7:0]  HS_SERVER_HELLO = 8'd2;
    localparam logic [15:0] TLS13_VER       = 16'h0304;
    localparam logic [15:0] CIPHER_AES128   = 16'h1301;
    localparam logic [15:0] EXT_SUPP_VER    = 16'h002b;
    localparam logic [15:0] EXT_KEY_SHARE   = 16'h0033;
    localparam logic [15:0] GROUP_P256      = 16'h0017;
    localparam logic [7:0]  SEC1_UNCOMP     = 8'h04;

    // byte positions inside the record
    localparam logic [15:0] POS_LEN_LO      = 16'd4;
    localparam logic [15:0] POS_HS_TYPE     = 16'd5;
    localparam logic [15:0] POS_BODY_LEN_LO = 16'd8;
    localparam logic [15:0] POS_LEGACY_LO   = 16'd10;
    localparam logic [15:0] POS_RANDOM      = 16'd11;
    localparam logic [15:0] POS_SESSION     = 16'd43;
    localparam logic [16:0] HS_BODY_POS     = 17'd9;
    localparam logic [23:0] MIN_BODY        = 24'd35;

    typedef enum logic [1:0] {
        KIND_RANDOM = 2'd0,
        KIND_KEY    = 2'd1,
        KIND_FINAL  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_PARSE_FAIL  = 2'd1,
        ST_UNSUPPORTED = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        PH_HDR, PH_SESS, PH_CIPH_HI, PH_CIPH_LO, PH_COMP, PH_XL_HI, PH_XL_LO,
        PH_XT_HI, PH_XT_LO, PH_XN_HI, PH_XN_LO, PH_XSKIP, PH_SV_HI, PH_SV_LO,
        PH_KG_HI, PH_KG_LO, PH_KL_HI, PH_KL_LO, PH_KFMT, PH_KEY, PH_TAIL,
        PH_DRAIN
    } phase_t;

    // up to two results caused by one input word
    typedef struct packed {
        logic        has_byte;
        logic        is_key;
        logic [5:0]  idx;
        logic [7:0]  val;
        logic        has_final;
        status_t     status;
        logic [15:0] cipher;
        logic [15:0] version;
    } pkt_t;

endpackage

`default_nettype wire

FILE: rtl/shp_front.sv
// ----------------------------------------------------------------------------
// shp_front
// byte parser: walks the record one word per cycle while words are accepted and builds result packets
// ----------------------------------------------------------------------------
`default_nettype none

module shp_front
    import shp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       acc,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output pkt_t            pkt,
    output logic            pkt_valid
);

    logic [15:0] pos_reg, pos_next;
    phase_t      phase_reg, phase_next;
    logic [15:0] rec_len_reg, rec_len_next;
    logic [16:0] hs_end_reg, hs_end_next;
    logic [16:0] sess_end_reg, sess_end_next;
    logic [16:0] ext_end_reg, ext_end_next;
    logic [16:0] cur_end_reg, cur_end_next;
    logic [15:0] cur_type_reg, cur_type_next;
    logic [23:0] fs_reg, fs_next;
    logic [15:0] legacy_reg, legacy_next;
    logic [15:0] cipher_reg, cipher_next;
    logic [15:0] version_reg, version_next;
    logic        have_ver_reg, have_ver_next;
    logic        have_key_reg, have_key_next;
    status_t     err_reg, err_next;

    // parse step and end-of-message status
    always_comb
    begin
        logic [15:0] v16;
        logic [16:0] p17;
        logic [16:0] p1;
        logic [16:0] tmp_end;
        logic [16:0] diff;
        logic        overlong;
        logic        fail;
        status_t     fail_code;
        status_t     st;

        pos_next      = pos_reg;
        phase_next    = phase_reg;
        rec_len_next  = rec_len_reg;
        hs_end_next   = hs_end_reg;
        sess_end_next = sess_end_reg;
        ext_end_next  = ext_end_reg;
        cur_end_next  = cur_end_reg;
        cur_type_next = cur_type_reg;
        fs_next       = fs_reg;
        legacy_next   = legacy_reg;
        cipher_next   = cipher_reg;
        version_next  = version_reg;
        have_ver_next = have_ver_reg;
        have_key_next = have_key_reg;
        err_next      = err_reg;
        pkt           = '0;
        fail          = 1'b0;
        fail_code     = ST_PARSE_FAIL;
        st            = ST_OK;
        overlong      = (pos_reg == 16'hFFFF);
        p17           = {1'b0, pos_reg};
        p1            = p17 + 17'd1;
        tmp_end       = '0;
        diff          = cur_end_reg - p17;
        v16           = {fs_reg[7:0], data_byte};

        if (!overlong)
        begin
            fs_next  = {fs_reg[15:0], data_byte};
            pos_next = pos_reg + 16'd1;
            unique case (phase_reg)
                PH_HDR:
                begin
                    if (pos_reg == 16'd0)
                    begin
                        if (data_byte != REC_TYPE_HS) fail = 1'b1;
                    end
                    else if (pos_reg == 16'd2)
                    begin
                        if (v16 != LEGACY_VER) fail = 1'b1;
                    end
                    else if (pos_reg == POS_LEN_LO)
                    begin
                        rec_len_next = v16;
                    end
                    else if (pos_reg == POS_HS_TYPE)
                    begin
                        if (data_byte != HS_SERVER_HELLO) fail = 1'b1;
                    end
                    else if (pos_reg == POS_BODY_LEN_LO)
                    begin
                        if (rec_len_reg < 16'd4 ||
                            fs_next > {8'd0, rec_len_reg - 16'd4})
                            fail = 1'b1;
                        else if (fs_next < MIN_BODY)
                            fail = 1'b1;
                        else
                            hs_end_next = HS_BODY_POS + fs_next[16:0];
                    end
                    else if (pos_reg == POS_LEGACY_LO)
                    begin
                        legacy_next = v16;
                    end
                    else if (pos_reg >= POS_RANDOM && pos_reg < POS_SESSION)
                    begin
                        pkt.has_byte = 1'b1;
                        pkt.is_key   = 1'b0;
                        pkt.idx      = 6'(pos_reg - POS_RANDOM);
                        pkt.val      = data_byte;
                    end
                    else if (pos_reg == POS_SESSION)
                    begin
                        if ({9'd0, data_byte} > hs_end_reg - 17'(POS_SESSION + 16'd1))
                            fail = 1'b1;
                        else
                        begin
                            sess_end_next = 17'(POS_SESSION + 16'd1) + {9'd0, data_byte};
                            if (hs_end_reg - sess_end_next < 17'd5)
                                fail = 1'b1;
                            else
                                phase_next = (data_byte != 8'd0) ? PH_SESS : PH_CIPH_HI;
                        end
                    end
                end
                PH_SESS:
                    if (p1 >= sess_end_reg) phase_next = PH_CIPH_HI;
                PH_CIPH_HI: phase_next = PH_CIPH_LO;
                PH_CIPH_LO:
                begin
                    cipher_next = v16;
                    phase_next  = PH_COMP;
                end
                PH_COMP:
                    if (data_byte != 8'd0)
                    begin
                        fail      = 1'b1;
                        fail_code = ST_UNSUPPORTED;
                    end
                    else
                        phase_next = PH_XL_HI;
                PH_XL_HI: phase_next = PH_XL_LO;
                PH_XL_LO:
                    if ({1'b0, v16} > hs_end_reg - p1)
                        fail = 1'b1;
                    else
                    begin
                        ext_end_next = p1 + {1'b0, v16};
                        phase_next   = (v16 == 16'd0) ? PH_TAIL : PH_XT_HI;
                    end
                PH_XT_HI:
                    if (p17 + 17'd4 > ext_end_reg) fail = 1'b1;
                    else phase_next = PH_XT_LO;
                PH_XT_LO:
                begin
                    cur_type_next = v16;
                    phase_next    = PH_XN_HI;
                end
                PH_XN_HI: phase_next = PH_XN_LO;
                PH_XN_LO:
                    if ({1'b0, v16} > ext_end_reg - p1)
                        fail = 1'b1;
                    else
                    begin
                        tmp_end      = p1 + {1'b0, v16};
                        cur_end_next = tmp_end;
                        if (cur_type_reg == EXT_SUPP_VER)
                        begin
                            if (v16 != 16'd2) fail = 1'b1;
                            else phase_next = PH_SV_HI;
                        end
                        else if (cur_type_reg == EXT_KEY_SHARE)
                        begin
                            if (v16 != 16'(PUBLIC_KEY_BYTES + 5)) fail = 1'b1;
                            else phase_next = PH_KG_HI;
                        end
                        else if (v16 == 16'd0)
                            phase_next = (tmp_end >= ext_end_reg) ? PH_TAIL : PH_XT_HI;
                        else
                            phase_next = PH_XSKIP;
                    end
                PH_XSKIP:
                    if (p1 >= cur_end_reg)
                        phase_next = (cur_end_reg >= ext_end_reg) ? PH_TAIL : PH_XT_HI;
                PH_SV_HI: phase_next = PH_SV_LO;
                PH_SV_LO:
                begin
                    version_next  = v16;
                    have_ver_next = 1'b1;
                    phase_next    = (cur_end_reg >= ext_end_reg) ? PH_TAIL : PH_XT_HI;
                end
                PH_KG_HI: phase_next = PH_KG_LO;
                PH_KG_LO:
                    if (v16 != GROUP_P256) fail = 1'b1;
                    else phase_next = PH_KL_HI;
                PH_KL_HI: phase_next = PH_KL_LO;
                PH_KL_LO:
                    if (v16 != 16'(PUBLIC_KEY_BYTES + 1)) fail = 1'b1;
                    else phase_next = PH_KFMT;
                PH_KFMT:
                    if (data_byte != SEC1_UNCOMP) fail = 1'b1;
                    else phase_next = PH_KEY;
                PH_KEY:
                begin
                    pkt.has_byte = 1'b1;
                    pkt.is_key   = 1'b1;
                    pkt.idx      = 6'(17'(PUBLIC_KEY_BYTES) - diff);
                    pkt.val      = data_byte;
                    if (diff <= 17'd1)
                    begin
                        have_key_next = 1'b1;
                        phase_next    = (cur_end_reg >= ext_end_reg) ? PH_TAIL : PH_XT_HI;
                    end
                end
                default: ;
            endcase
        end

        // first failure wins, parsing stops
        if (fail)
        begin
            if (err_reg == ST_OK) err_next = fail_code;
            phase_next = PH_DRAIN;
        end

        // final status on the marked word, then clear for the next message
        if (last_byte)
        begin
            if (overlong || p1 < HS_BODY_POS)
                st = ST_PARSE_FAIL;
            else if ({1'b0, rec_len_next} > p1 - 17'd5)
                st = ST_PARSE_FAIL;
            else if (hs_end_next > p1)
                st = ST_PARSE_FAIL;
            else if (err_next != ST_OK)
                st = err_next;
            else if (phase_next != PH_TAIL)
                st = ST_PARSE_FAIL;
            else if (legacy_next != LEGACY_VER || cipher_next != CIPHER_AES128 ||
                     !have_ver_next || version_next != TLS13_VER || !have_key_next)
                st = ST_UNSUPPORTED;
            else
                st = ST_OK;
            pkt.has_final = 1'b1;
            pkt.status    = st;
            pkt.cipher    = cipher_next;
            pkt.version   = version_next;

            pos_next      = '0;
            phase_next    = PH_HDR;
            rec_len_next  = '0;
            hs_end_next   = '0;
            sess_end_next = '0;
            ext_end_next  = '0;
            cur_end_next  = '0;
            cur_type_next = '0;
            fs_next       = '0;
            legacy_next   = '0;
            cipher_next   = '0;
            version_next  = '0;
            have_ver_next = 1'b0;
            have_key_next = 1'b0;
            err_next      = ST_OK;
        end

        pkt_valid = acc && (pkt.has_byte || pkt.has_final);
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            phase_reg    <= PH_HDR;
            rec_len_reg  <= '0;
            hs_end_reg   <= '0;
            sess_end_reg <= '0;
            ext_end_reg  <= '0;
            cur_end_reg  <= '0;
            cur_type_reg <= '0;
            fs_reg       <= '0;
            legacy_reg   <= '0;
            cipher_reg   <= '0;
            version_reg  <= '0;
            have_ver_reg <= 1'b0;
            have_key_reg <= 1'b0;
            err_reg      <= ST_OK;
        end
        else if (acc)
        begin
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            rec_len_reg  <= rec_len_next;
            hs_end_reg   <= hs_end_next;
            sess_end_reg <= sess_end_next;
            ext_end_reg  <= ext_end_next;
            cur_end_reg  <= cur_end_next;
            cur_type_reg <= cur_type_next;
            fs_reg       <= fs_next;
            legacy_reg   <= legacy_next;
            cipher_reg   <= cipher_next;
            version_reg  <= version_next;
            have_ver_reg <= have_ver_next;
            have_key_reg <= have_key_next;
            err_reg      <= err_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/shp_queue.sv
// ----------------------------------------------------------------------------
// shp_queue
// short packet queue between the parser and the result side
// ----------------------------------------------------------------------------
`default_nettype none

module shp_queue
    import shp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  pkt_t      wr_pkt,
    input  wire logic rd_en,
    output pkt_t      rd_pkt,
    output logic      full,
    output logic      not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pkt_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_pkt    = mem[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (wr_en && !rd_en)
            count_next = count_reg + CW'(1);
        else if (rd_en && !wr_en)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // packet storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_pkt;
    end

endmodule

`default_nettype wire

FILE: rtl/shp_back.sv
// ----------------------------------------------------------------------------
// shp_back
// result side: splits each queued packet into its byte word, its status word, or byte word then status word
// ----------------------------------------------------------------------------
`default_nettype none

module shp_back
    import shp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  pkt_t             head,
    input  wire logic        head_valid,
    input  wire logic        pop,
    output logic             deq,
    output logic             empty,
    output logic [1:0]       result_kind,
    output logic [5:0]       byte_index,
    output logic [7:0]       byte_value,
    output logic [1:0]       status,
    output logic [15:0]      chosen_suite,
    output logic [15:0]      negotiated_version,
    output logic             last_result
);

    logic sub_reg, sub_next;
    logic show_byte;
    logic fire;

    assign empty     = !head_valid;
    assign show_byte = head.has_byte && !sub_reg;
    assign fire      = pop && head_valid;
    assign deq       = fire && !(show_byte && head.has_final);

    // result word selection
    always_comb
    begin
        if (show_byte)
        begin
            result_kind        = head.is_key ? KIND_KEY : KIND_RANDOM;
            byte_index         = head.idx;
            byte_value         = head.val;
            status             = ST_OK;
            chosen_suite       = '0;
            negotiated_version = '0;
            last_result        = 1'b0;
        end
        else
        begin
            result_kind        = KIND_FINAL;
            byte_index         = '0;
            byte_value         = '0;
            status             = head.status;
            chosen_suite       = head.cipher;
            negotiated_version = head.version;
            last_result        = 1'b1;
        end
    end

    // byte half already delivered
    always_comb
    begin
        sub_next = sub_reg;
        if (fire)
            sub_next = !deq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sub_reg <= 1'b0;
        else
            sub_reg <= sub_next;
    end

endmodule

`default_nettype wire

FILE: rtl/server_hello_parser_top.sv
// a word's results are written into the packet queue and wait there behind earlier results until popped
// throughput: one byte word per cycle while full is low; a word with a byte and a status takes two pops
// full rises only when the packet queue between parser and result side fills up
// reset: rst_n clears parser state, queue pointers and the split flag at once
// ----------------------------------------------------------------------------
// server_hello_parser_top
// server hello record parser with a decoupled result queue
// ----------------------------------------------------------------------------
`default_nettype none

module server_hello_parser_top
    import shp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       result_kind,
    output logic [5:0]       byte_index,
    output logic [7:0]       byte_value,
    output logic [1:0]       status,
    output logic [15:0]      chosen_suite,
    output logic [15:0]      negotiated_version,
    output logic             last_result
);

    pkt_t pkt;
    pkt_t head;
    logic pkt_valid;
    logic head_valid;
    logic deq;
    logic acc;

    assign acc = push && !full;

    shp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .pkt       (pkt),
        .pkt_valid (pkt_valid)
    );

    shp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (pkt_valid),
        .wr_pkt    (pkt),
        .rd_en     (deq),
        .rd_pkt    (head),
        .full      (full),
        .not_empty (head_valid)
    );

    shp_back u_back
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .head               (head),
        .head_valid         (head_valid),
        .pop                (pop),
        .deq                (deq),
        .empty              (empty),
        .result_kind        (result_kind),
        .byte_index         (byte_index),
        .byte_value         (byte_value),
        .status             (status),
        .chosen_suite       (chosen_suite),
        .negotiated_version (negotiated_version),
        .last_result        (last_result)
    );

endmodule

`default_nettype wire

FILE: rtl/shp_checker.sv
// ----------------------------------------------------------------------------
// shp_checker
// port-level checks on the server hello parser result side
// ----------------------------------------------------------------------------
`default_nettype none

`include "server_hello_parser_top_defines.svh"

module shp_checker
    import shp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [1:0]  result_kind,
    input wire logic [5:0]  byte_index,
    input wire logic [1:0]  status,
    input wire logic        last_result
);

    `SHP_ASSERT_NOW(a_last_is_final, !empty && last_result, result_kind == KIND_FINAL)
    `SHP_ASSERT_NOW(a_byte_no_status, !empty && result_kind != KIND_FINAL, status == ST_OK)
    `SHP_ASSERT_NOW(a_random_index, !empty && result_kind == KIND_RANDOM,
                    byte_index < 6'(RANDOM_BYTES))
    `SHP_ASSERT_NEXT(a_stall_holds, !empty && !pop, !empty && $stable(result_kind))

endmodule

bind server_hello_parser_top shp_checker u_shp_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .result_kind (result_kind),
    .byte_index  (byte_index),
    .status      (status),
    .last_result (last_result)
);

`default_nettype wire
